/* sv/mi3_pkg.sv */
// shared constants, types and helpers for the 3x3 matrix inverse core
// no dependencies
package mi3_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int THR_BITS = 32;
	localparam logic [THR_BITS-1:0] THR_RESET = 32'd43;
	localparam int N_ELEM = 9;

	typedef logic [3:0] eidx_t;

	// cofactor k = elem[A]*elem[B] - elem[C]*elem[D], adjugate in storage order
	localparam eidx_t COF_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam eidx_t COF_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam eidx_t COF_C [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam eidx_t COF_D [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

	// width of the determinant after the fraction shift
	function automatic int det_bits(input int w, input int f);
		return 3 * w + 3 - f;
	endfunction

endpackage

/* sv/mi3_cofactor.sv */
// cofactor stages: 18 products, then nine exact 2x2 cofactors
// depends on mi3_pkg
module mi3_cofactor
	import mi3_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic signed [WORD_BITS-1:0] elem [N_ELEM],
	output logic                        out_vld,
	output logic signed [2*WORD_BITS:0] cof [N_ELEM],
	output logic signed [WORD_BITS-1:0] piv [3]
);

	localparam int PW = 2 * WORD_BITS;

	logic vld_s1, vld_s2;
	logic signed [PW-1:0] pa_s1 [N_ELEM];
	logic signed [PW-1:0] pb_s1 [N_ELEM];
	logic signed [PW:0] cof_s2 [N_ELEM];
	logic signed [WORD_BITS-1:0] piv_s1 [3];
	logic signed [WORD_BITS-1:0] piv_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_ELEM; k++) begin
			pa_s1[k] <= PW'(elem[COF_A[k]]) * PW'(elem[COF_B[k]]);
			pb_s1[k] <= PW'(elem[COF_C[k]]) * PW'(elem[COF_D[k]]);
			cof_s2[k] <= (PW+1)'(pa_s1[k]) - (PW+1)'(pb_s1[k]);
		end
		// expansion pivots are elements 0, 3 and 6
		for (int j = 0; j < 3; j++) begin
			piv_s1[j] <= elem[3*j];
			piv_s2[j] <= piv_s1[j];
		end
	end

	assign out_vld = vld_s2;
	assign cof = cof_s2;
	assign piv = piv_s2;

endmodule

/* sv/mi3_det.sv */
// determinant stages: split products, sum, shift, magnitude and singular test
// depends on mi3_pkg
module mi3_det
	import mi3_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [2*WORD_BITS:0]   cof [N_ELEM],
	input  logic signed [WORD_BITS-1:0]   piv [3],
	input  logic [THR_BITS-1:0]           thr,
	output logic                          out_vld,
	output logic [det_bits(WORD_BITS, FRAC_BITS)-1:0] adet,
	output logic                          det_neg,
	output logic                          singular,
	output logic [2*WORD_BITS:0]          cabs [N_ELEM],
	output logic                          cneg [N_ELEM]
);

	localparam int CW = 2 * WORD_BITS + 1;
	localparam int DW = 3 * WORD_BITS + 3;
	localparam int DETW = det_bits(WORD_BITS, FRAC_BITS);
	localparam int CMPW = (DETW > THR_BITS) ? DETW : THR_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [CW-1:0] plo_s1 [3];
	logic signed [CW-1:0] phi_s1 [3];
	logic signed [DW-1:0] term_s2 [3];
	logic signed [DW-1:0] dsum;
	logic signed [DETW-1:0] det_s3;
	logic [DETW-1:0] adet_s4, adet_s5;
	logic neg_s4, neg_s5, sing_s5;
	logic signed [CW-1:0] cof_s1 [N_ELEM];
	logic signed [CW-1:0] cof_s2 [N_ELEM];
	logic signed [CW-1:0] cof_s3 [N_ELEM];
	logic [CW-1:0] cabs_s4 [N_ELEM];
	logic [CW-1:0] cabs_s5 [N_ELEM];
	logic cneg_s4 [N_ELEM];
	logic cneg_s5 [N_ELEM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign dsum = term_s2[0] + term_s2[1] + term_s2[2];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			// pivot times low and high halves of its cofactor
			plo_s1[j] <= CW'(piv[j]) * CW'($signed({1'b0, cof[j][WORD_BITS-1:0]}));
			phi_s1[j] <= CW'(piv[j]) * CW'($signed(cof[j][CW-1:WORD_BITS]));
			term_s2[j] <= (DW'(phi_s1[j]) <<< WORD_BITS) + DW'(plo_s1[j]);
		end
		det_s3 <= DETW'(dsum >>> FRAC_BITS);
		neg_s4 <= det_s3[DETW-1];
		adet_s4 <= det_s3[DETW-1] ? DETW'(-det_s3) : DETW'(det_s3);
		neg_s5 <= neg_s4;
		adet_s5 <= adet_s4;
		sing_s5 <= (adet_s4 == '0) || (CMPW'(adet_s4) < CMPW'(thr));
		for (int k = 0; k < N_ELEM; k++) begin
			cof_s1[k] <= cof[k];
			cof_s2[k] <= cof_s1[k];
			cof_s3[k] <= cof_s2[k];
			cneg_s4[k] <= cof_s3[k][CW-1];
			cabs_s4[k] <= cof_s3[k][CW-1] ? CW'(-cof_s3[k]) : CW'(cof_s3[k]);
			cneg_s5[k] <= cneg_s4[k];
			cabs_s5[k] <= cabs_s4[k];
		end
	end

	assign out_vld = vld_s5;
	assign adet = adet_s5;
	assign det_neg = neg_s5;
	assign singular = sing_s5;
	assign cabs = cabs_s5;
	assign cneg = cneg_s5;

endmodule

/* sv/mi3_div.sv */
// one divider lane: restoring division, one quotient bit per stage, then saturation
// depends on mi3_pkg
module mi3_div
	import mi3_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic [2*WORD_BITS:0]          num,
	input  logic [det_bits(WORD_BITS, FRAC_BITS)-1:0] den,
	input  logic                          neg,
	input  logic                          sing,
	output logic signed [WORD_BITS-1:0]   res
);

	localparam int CW = 2 * WORD_BITS + 1;
	localparam int DETW = det_bits(WORD_BITS, FRAC_BITS);
	localparam int NW = CW + FRAC_BITS;
	localparam int XW = (DETW + WORD_BITS > NW) ? DETW + WORD_BITS : NW;
	localparam logic [WORD_BITS-1:0] HALF = WORD_BITS'(1) << (WORD_BITS - 1);

	logic [XW-1:0] rem_s [WORD_BITS];
	logic [DETW-1:0] den_s [WORD_BITS];
	logic [WORD_BITS-1:0] q_s [WORD_BITS];
	logic neg_s [WORD_BITS];
	logic sing_s [WORD_BITS];
	logic big_s [WORD_BITS];
	logic [WORD_BITS-1:0] mag;
	logic [WORD_BITS-1:0] res_d;
	logic [WORD_BITS-1:0] res_q;

	always_ff @(posedge clk) begin
		// quotient at or above 2^WORD_BITS saturates unless the item is singular
		rem_s[0] <= XW'(num) << FRAC_BITS;
		big_s[0] <= (XW'(num) << FRAC_BITS) >= (XW'(den) << WORD_BITS);
		q_s[0] <= '0;
		den_s[0] <= den;
		neg_s[0] <= neg;
		sing_s[0] <= sing;
		for (int i = 1; i < WORD_BITS; i++) begin
			if (rem_s[i-1] >= (XW'(den_s[i-1]) << (WORD_BITS - i))) begin
				rem_s[i] <= rem_s[i-1] - (XW'(den_s[i-1]) << (WORD_BITS - i));
				q_s[i] <= q_s[i-1] | (WORD_BITS'(1) << (WORD_BITS - i));
			end else begin
				rem_s[i] <= rem_s[i-1];
				q_s[i] <= q_s[i-1];
			end
			den_s[i] <= den_s[i-1];
			neg_s[i] <= neg_s[i-1];
			sing_s[i] <= sing_s[i-1];
			big_s[i] <= big_s[i-1];
		end
		res_q <= res_d;
	end

	// last quotient bit, saturation and the zero result for singular items
	always_comb begin
		mag = q_s[WORD_BITS-1] |
			WORD_BITS'(rem_s[WORD_BITS-1] >= XW'(den_s[WORD_BITS-1]));
		if (sing_s[WORD_BITS-1]) begin
			res_d = '0;
		end else if (neg_s[WORD_BITS-1]) begin
			res_d = (big_s[WORD_BITS-1] || mag > HALF) ? HALF : ('0 - mag);
		end else begin
			res_d = (big_s[WORD_BITS-1] || mag >= HALF) ? ~HALF : mag;
		end
	end

	assign res = $signed(res_q);

endmodule

/* sv/matrix_inverse_3x3_core.sv */
// top level of the 3x3 matrix inverse core (adjugate over determinant)
// depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div
//
// channel   ports                          handshake
// input     start, busy, elem0..elem8      taken when start && !busy
// result    done, inv0..inv8, invertible   one-cycle strobe on done
// config    cfg_we, cfg_wdata              singular_threshold written when cfg_we
//
// one item per cycle; the pipeline is built from
// 2 cofactor stages, 5 determinant stages, WORD_BITS+1 divider stages,
// where the divider lanes resolve one quotient bit per stage
// busy is always low: every stage advances each cycle, nothing stalls
// arst_n clears all valid bits and loads the threshold with 43
module matrix_inverse_3x3_core
	import mi3_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cfg_we,
	input  logic [THR_BITS-1:0]         cfg_wdata,
	input  logic signed [WORD_BITS-1:0] elem0,
	input  logic signed [WORD_BITS-1:0] elem1,
	input  logic signed [WORD_BITS-1:0] elem2,
	input  logic signed [WORD_BITS-1:0] elem3,
	input  logic signed [WORD_BITS-1:0] elem4,
	input  logic signed [WORD_BITS-1:0] elem5,
	input  logic signed [WORD_BITS-1:0] elem6,
	input  logic signed [WORD_BITS-1:0] elem7,
	input  logic signed [WORD_BITS-1:0] elem8,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] inv0,
	output logic signed [WORD_BITS-1:0] inv1,
	output logic signed [WORD_BITS-1:0] inv2,
	output logic signed [WORD_BITS-1:0] inv3,
	output logic signed [WORD_BITS-1:0] inv4,
	output logic signed [WORD_BITS-1:0] inv5,
	output logic signed [WORD_BITS-1:0] inv6,
	output logic signed [WORD_BITS-1:0] inv7,
	output logic signed [WORD_BITS-1:0] inv8,
	output logic                        invertible
);

	localparam int CW = 2 * WORD_BITS + 1;
	localparam int DETW = det_bits(WORD_BITS, FRAC_BITS);
	localparam int DIV_LAT = WORD_BITS + 1;
	localparam int LAT = 7 + DIV_LAT;

	// singular threshold register
	logic [THR_BITS-1:0] thr_q;

	logic signed [WORD_BITS-1:0] elem_arr [N_ELEM];
	logic signed [WORD_BITS-1:0] inv_arr [N_ELEM];

	// cofactor stage outputs
	logic cof_vld;
	logic signed [CW-1:0] cof [N_ELEM];
	logic signed [WORD_BITS-1:0] piv [3];

	// determinant stage outputs
	logic det_vld;
	logic [DETW-1:0] adet;
	logic det_neg;
	logic singular;
	logic [CW-1:0] cabs [N_ELEM];
	logic cneg [N_ELEM];

	// valid and invertible flag run beside the divider lanes
	logic vld_s [DIV_LAT];
	logic ok_s [DIV_LAT];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign elem_arr[0] = elem0;
	assign elem_arr[1] = elem1;
	assign elem_arr[2] = elem2;
	assign elem_arr[3] = elem3;
	assign elem_arr[4] = elem4;
	assign elem_arr[5] = elem5;
	assign elem_arr[6] = elem6;
	assign elem_arr[7] = elem7;
	assign elem_arr[8] = elem8;

	mi3_cofactor #(
		.WORD_BITS(WORD_BITS)
	) u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start && !busy),
		.elem   (elem_arr),
		.out_vld(cof_vld),
		.cof    (cof),
		.piv    (piv)
	);

	mi3_det #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_det (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cof_vld),
		.cof     (cof),
		.piv     (piv),
		.thr     (thr_q),
		.out_vld (det_vld),
		.adet    (adet),
		.det_neg (det_neg),
		.singular(singular),
		.cabs    (cabs),
		.cneg    (cneg)
	);

	// nine independent divider lanes, one per inverse element
	for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
		mi3_div #(
			.WORD_BITS(WORD_BITS),
			.FRAC_BITS(FRAC_BITS)
		) u_div (
			.clk (clk),
			.num (cabs[k]),
			.den (adet),
			.neg (cneg[k] ^ det_neg),
			.sing(singular),
			.res (inv_arr[k])
		);
	end

	// valid bits reset, the invertible flag is payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= det_vld;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_s[0] <= !singular;
		for (int i = 1; i < DIV_LAT; i++) begin
			ok_s[i] <= ok_s[i-1];
		end
	end

	assign done = vld_s[DIV_LAT-1];
	assign invertible = ok_s[DIV_LAT-1];
	assign inv0 = inv_arr[0];
	assign inv1 = inv_arr[1];
	assign inv2 = inv_arr[2];
	assign inv3 = inv_arr[3];
	assign inv4 = inv_arr[4];
	assign inv5 = inv_arr[5];
	assign inv6 = inv_arr[6];
	assign inv7 = inv_arr[7];
	assign inv8 = inv_arr[8];

`ifndef SYNTHESIS
	// a singular item carries an all-zero matrix
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !invertible) |-> (inv0 == '0 && inv1 == '0 && inv2 == '0 &&
			inv3 == '0 && inv4 == '0 && inv5 == '0 && inv6 == '0 &&
			inv7 == '0 && inv8 == '0))
		else $error("singular item with nonzero elements");

	// every result traces back to an accepted item
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without an accepted item");

	// every accepted item yields a result after the fixed latency
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted item lost in the pipeline");

	// threshold write takes effect on the next cycle
	a_thr_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (thr_q == $past(cfg_wdata)))
		else $error("threshold write lost");
`endif

endmodule

/* tb/tb_top.sv */
// testbench for matrix_inverse_3x3_core: directed and random 3x3 matrices checked
// against a bit-exact fixed-point adjugate/determinant predictor in a scoreboard class
// depends on matrix_inverse_3x3_core and mi3_pkg
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mi3_pkg::*;

	localparam int LATENCY   = 40;
	localparam int WDOG_MAX  = 3000;
	localparam int N_RANDOM  = 400;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;

	typedef logic signed [31:0] mat_t [9];
	typedef struct {
		mat_t inv;
		logic ok;
	} inverse_t;

	// holds the threshold copy and the inverses still in flight
	class inverse_board;
		logic [31:0] threshold = THR_RESET;
		inverse_t pending[$];
		int errors = 0;

		// exact adjugate over determinant, Q16.16 out, truncated and saturated
		function automatic inverse_t predict(mat_t e);
			logic signed [127:0] m[9], c[9], det, adet, q, mag;
			inverse_t r;
			logic neg;
			for (int k = 0; k < 9; k++) m[k] = e[k];
			c[0] = m[4]*m[8] - m[5]*m[7];
			c[1] = m[2]*m[7] - m[1]*m[8];
			c[2] = m[1]*m[5] - m[2]*m[4];
			c[3] = m[5]*m[6] - m[3]*m[8];
			c[4] = m[0]*m[8] - m[2]*m[6];
			c[5] = m[2]*m[3] - m[0]*m[5];
			c[6] = m[3]*m[7] - m[4]*m[6];
			c[7] = m[1]*m[6] - m[0]*m[7];
			c[8] = m[0]*m[4] - m[1]*m[3];
			// floor shift leaves Q51.32, the width of the core's determinant
			det = (m[0]*c[0] + m[3]*c[1] + m[6]*c[2]) >>> 16;
			adet = det < 0 ? -det : det;
			r.ok = 1'b0;
			for (int k = 0; k < 9; k++) r.inv[k] = '0;
			if (adet == 0 || adet < $signed({96'd0, threshold})) return r;
			r.ok = 1'b1;
			for (int k = 0; k < 9; k++) begin
				mag = c[k] < 0 ? -c[k] : c[k];
				q = (mag <<< 16) / adet;
				neg = (c[k] < 0) ^ (det < 0);
				if (neg) begin
					if (q > 128'sh8000_0000) q = 128'sh8000_0000;
					q = -q;
				end else if (q > 128'sh7fff_ffff) begin
					q = 128'sh7fff_ffff;
				end
				r.inv[k] = q[31:0];
			end
			return r;
		endfunction

		function void note_matrix(mat_t e);
			pending.push_back(predict(e));
		endfunction

		function void check_inverse(mat_t got, logic ok);
			inverse_t x;
			if (pending.size() == 0) begin
				$error("unexpected result, nothing pending");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (ok !== x.ok) begin
				$error("invertible expected %0d actual %0d", x.ok, ok);
				errors++;
			end
			for (int k = 0; k < 9; k++)
				if (got[k] !== x.inv[k]) begin
					$error("inv%0d expected %0d actual %0d", k, x.inv[k], got[k]);
					errors++;
				end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic signed [31:0] elem0 = '0, elem1 = '0, elem2 = '0, elem3 = '0, elem4 = '0;
	logic signed [31:0] elem5 = '0, elem6 = '0, elem7 = '0, elem8 = '0;
	logic done, invertible;
	logic signed [31:0] inv0, inv1, inv2, inv3, inv4, inv5, inv6, inv7, inv8;

	inverse_board board = new();
	int idle_pct = 16;
	int quiet = 0;

	always #5 clk = ~clk;

	matrix_inverse_3x3_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.elem0(elem0), .elem1(elem1), .elem2(elem2), .elem3(elem3), .elem4(elem4),
		.elem5(elem5), .elem6(elem6), .elem7(elem7), .elem8(elem8),
		.done(done),
		.inv0(inv0), .inv1(inv1), .inv2(inv2), .inv3(inv3), .inv4(inv4),
		.inv5(inv5), .inv6(inv6), .inv7(inv7), .inv8(inv8),
		.invertible(invertible)
	);

	// monitor: sample handshakes on the edge, inputs were driven by nba so no race
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note_matrix('{elem0, elem1, elem2, elem3, elem4,
					elem5, elem6, elem7, elem8});
			end
			if (done) begin
				board.check_inverse('{inv0, inv1, inv2, inv3, inv4,
					inv5, inv6, inv7, inv8}, invertible);
			end
			// watchdog on cycles with no traffic on either side
			if ((start && !busy) || done) begin
				quiet <= 0;
			end else if (quiet >= WDOG_MAX) begin
				$display("tb_top failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// one item; start stays high across back-to-back items, dropped only in gaps
	task automatic send_matrix(mat_t a);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{elem0, elem1, elem2, elem3, elem4} <= {a[0], a[1], a[2], a[3], a[4]};
		{elem5, elem6, elem7, elem8} <= {a[5], a[6], a[7], a[8]};
		do @(posedge clk); while (busy);
	endtask

	// let the pipeline empty before touching the register
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.threshold = v;
	endtask

	// random matrix: small entries reach the interesting range, full entries hit every bit
	function automatic mat_t random_matrix();
		mat_t a;
		int kind;
		kind = $urandom_range(3);
		for (int k = 0; k < 9; k++) begin
			case (kind)
				0: a[k] = $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
				1: a[k] = $signed($urandom_range(32'h0000_0400)) - 32'sh0000_0200;
				2: a[k] = $urandom();
				default: a[k] = (k % 4 == 0) ? $signed($urandom_range(ONE * 4))
					: $signed($urandom_range(255)) - 128;
			endcase
		end
		// sometimes force a dependent column for singular cases
		if ($urandom_range(9) == 0) begin
			a[2] = a[0]; a[5] = a[3]; a[8] = a[6];
		end
		return a;
	endfunction

	task automatic directed_set();
		mat_t a;
		send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
		send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_matrix('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
		send_matrix('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
		send_matrix('{MAXV, 0, 0, 0, MINV, 0, 0, 0, MAXV});
		send_matrix('{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV});
		// tiny diagonals: the determinant shifts to zero, so both count as singular
		send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
		send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, -1});
		send_matrix('{-ONE, 0, 0, 0, 2*ONE, 0, 0, 0, ONE/2});
		// rank one, singular
		send_matrix('{ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, -ONE, -2*ONE, -3*ONE});
		// small determinants above the reset threshold of 43
		send_matrix('{32'sd256, 0, 0, 0, 32'sd256, 0, 0, 0, 32'sd256});
		send_matrix('{32'sd212, 0, 0, 0, 32'sd212, 0, 0, 0, 32'sd212});
		send_matrix('{32'sd211, 0, 0, 0, 32'sd212, 0, 0, 0, 32'sd212});
		send_matrix('{ONE, ONE/3, -ONE/7, 5*ONE, -2*ONE, ONE, 3, -ONE, 9*ONE});
		send_matrix('{MAXV, MINV, 1, -1, MAXV, MINV, 0, 1, MAXV});
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 9; k++) a[k] = $urandom();
			send_matrix(a);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_set();
		// zero threshold: only an exact zero determinant counts as singular
		write_threshold(32'd0);
		send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
		send_matrix('{32'sd255, 0, 0, 0, 32'sd256, 0, 0, 0, 32'sd256});
		send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
		write_threshold(32'hffff_ffff);
		send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
		send_matrix('{ONE - 1, 0, 0, 0, ONE, 0, 0, 0, ONE});
		for (int i = 0; i < N_RANDOM; i++) begin
			// three idle phases plus threshold changes in between
			if (i == N_RANDOM / 3) idle_pct = 81;
			if (i == 2 * N_RANDOM / 3) idle_pct = 0;
			if (i % 100 == 50) write_threshold($urandom());
			if (i % 100 == 99) write_threshold(i < 200 ? THR_RESET : 32'd0);
			send_matrix(random_matrix());
		end
		drain();
		if (board.errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
